// ----- hw/rtl/trcc_pkg.sv -----
`default_nettype none

package trcc_pkg;

   // stream and register port widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned DEB_CNT_W = 4;

   // prescaler divides: 10 ms -> 50 ms -> 1 s -> 1 min
   localparam logic [2:0] FIFTY_DIV  = 3'd5;
   localparam logic [4:0] SECOND_DIV = 5'd20;
   localparam logic [5:0] MINUTE_DIV = 6'd60;

   // register reset values
   localparam logic [7:0]           FAST_PERIOD_RST = 8'd50;
   localparam logic [7:0]           SLOW_PERIOD_RST = 8'd200;
   localparam logic [7:0]           LEAD_PAUSE_RST  = 8'd150;
   localparam logic [7:0]           PULSE_LEN_RST   = 8'd20;
   localparam logic [DEB_CNT_W-1:0] DEB_LIMIT_RST   = 4'd10;

   typedef enum logic [2:0] {
      ACT_OFF        = 3'd0,
      ACT_ON         = 3'd1,
      ACT_ON_SECONDS = 3'd3,
      ACT_ON_MINUTES = 3'd4,
      ACT_CHIME_FAST = 3'd5,
      ACT_CHIME_SLOW = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      REG_FAST_PERIOD = 3'd0,
      REG_SLOW_PERIOD = 3'd1,
      REG_LEAD_PAUSE  = 3'd2,
      REG_PULSE_LEN   = 3'd3,
      REG_DEB_LIMIT   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic       switch_closed;
      logic       button2_closed;
      logic       button1_closed;
      logic [7:0] action_count;
      logic [2:0] act_code;
      logic [1:0] device_mask;
   } req_item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/trcc_debounce.sv -----
`default_nettype none

module trcc_debounce
   import trcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 sample_closed,
   input  wire logic [DEB_CNT_W-1:0] limit,
   output logic                      fire
);

   logic [DEB_CNT_W-1:0] count_ff, count_in;
   logic                 closed_ff, closed_in;

   always_comb begin
      count_in  = count_ff;
      closed_in = closed_ff;
      fire      = 1'b0;
      if (sample_closed) begin
         if (count_ff >= limit) begin
            // clamp without a report
            count_in = limit;
         end else begin
            count_in = count_ff + 1'b1;
            if (count_in == limit) begin
               closed_in = 1'b1;
               fire      = 1'b1;
            end
         end
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (count_in == '0) begin
            closed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else if (enable) begin
         count_ff  <= count_in;
         closed_ff <= closed_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/timed_relay_chime_controller_unit.sv -----
`default_nettype none

// channel   dir  handshake             payload
// req_*     in   req_tvalid/tready     tdata 16 b item fields, tuser command flag
// rsp_*     out  rsp_tvalid/tready     tdata 8 b relay levels and button pulses
// csr_*     in   psel/penable/pready   five registers at byte address 4*i
//
// One item per cycle while rsp_tready stays high. An accepted item is held in the
// input register, then one pass of counter logic writes the state and the result
// register, which raises rsp_tvalid. Synchronous reset clears all counters, relays
// and debouncers and loads register defaults. A stalled result holds the pipe; the
// input register still takes an item while it is empty or its item moves to the
// result register.

module timed_relay_chime_controller_unit
   import trcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [1:0] device_mask, [4:2] act_code, [12:5] action_count,
   // [13] button1_closed, [14] button2_closed, [15] switch_closed
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  wire logic                  req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] relay1_on, [1] relay2_on, [2] button1_pressed, [3] button2_pressed,
   // [7:4] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // configuration registers
   logic [7:0]           fast_period_ff;
   logic [7:0]           slow_period_ff;
   logic [7:0]           lead_pause_ff;
   logic [7:0]           pulse_len_ff;
   logic [DEB_CNT_W-1:0] deb_limit_ff;

   reg_index_type        csr_index;
   logic                 csr_write;

   // input register
   logic                 s1_valid_ff;
   logic                 s1_command_ff;
   req_item_type         s1_item_ff;
   logic                 advance;
   logic                 tick;

   // result register
   logic                 rsp_valid_ff;
   logic [3:0]           rsp_data_ff, rsp_data_in;

   // controller state
   logic [1:0] relay_ff, relay_in;
   logic [1:0] mask_ff, mask_in;
   logic [7:0] pause_ff, pause_in;
   logic [7:0] period_ff, period_in;
   logic [7:0] repeats_ff, repeats_in;
   logic [7:0] pulse_ff, pulse_in;
   logic [7:0] seconds_ff, seconds_in;
   logic [7:0] minutes_ff, minutes_in;
   logic [2:0] pre_fifty_ff, pre_fifty_in;
   logic [4:0] pre_second_ff, pre_second_in;
   logic [5:0] pre_minute_ff, pre_minute_in;

   logic       fire_b1, fire_b2, fire_sw;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= FAST_PERIOD_RST;
         slow_period_ff <= SLOW_PERIOD_RST;
         lead_pause_ff  <= LEAD_PAUSE_RST;
         pulse_len_ff   <= PULSE_LEN_RST;
         deb_limit_ff   <= DEB_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FAST_PERIOD: fast_period_ff <= csr_pwdata[7:0];
            REG_SLOW_PERIOD: slow_period_ff <= csr_pwdata[7:0];
            REG_LEAD_PAUSE:  lead_pause_ff  <= csr_pwdata[7:0];
            REG_PULSE_LEN:   pulse_len_ff   <= csr_pwdata[7:0];
            REG_DEB_LIMIT:   deb_limit_ff   <= csr_pwdata[DEB_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FAST_PERIOD: csr_prdata = {24'd0, fast_period_ff};
         REG_SLOW_PERIOD: csr_prdata = {24'd0, slow_period_ff};
         REG_LEAD_PAUSE:  csr_prdata = {24'd0, lead_pause_ff};
         REG_PULSE_LEN:   csr_prdata = {24'd0, pulse_len_ff};
         REG_DEB_LIMIT:   csr_prdata = {{(CSR_DATA_W-DEB_CNT_W){1'b0}}, deb_limit_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign tick       = !s1_command_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_item_ff    <= req_item_type'(req_tdata);
         s1_command_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-4){1'b0}}, rsp_data_ff};

   // ---------------- debouncers ----------------
   trcc_debounce u_deb_button1 (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance && tick),
      .sample_closed (s1_item_ff.button1_closed),
      .limit         (deb_limit_ff),
      .fire          (fire_b1)
   );

   trcc_debounce u_deb_button2 (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance && tick),
      .sample_closed (s1_item_ff.button2_closed),
      .limit         (deb_limit_ff),
      .fire          (fire_b2)
   );

   trcc_debounce u_deb_switch (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance && tick),
      .sample_closed (s1_item_ff.switch_closed),
      .limit         (deb_limit_ff),
      .fire          (fire_sw)
   );

   // ---------------- item update ----------------
   always_comb begin
      relay_in      = relay_ff;
      mask_in       = mask_ff;
      pause_in      = pause_ff;
      period_in     = period_ff;
      repeats_in    = repeats_ff;
      pulse_in      = pulse_ff;
      seconds_in    = seconds_ff;
      minutes_in    = minutes_ff;
      pre_fifty_in  = pre_fifty_ff;
      pre_second_in = pre_second_ff;
      pre_minute_in = pre_minute_ff;

      if (!tick) begin
         mask_in = s1_item_ff.device_mask;
         unique case (action_type'(s1_item_ff.act_code))
            ACT_OFF: relay_in = relay_ff & ~mask_in;
            ACT_ON:  relay_in = relay_ff | mask_in;
            ACT_ON_SECONDS: begin
               relay_in   = relay_ff | mask_in;
               seconds_in = s1_item_ff.action_count;
            end
            ACT_ON_MINUTES: begin
               relay_in   = relay_ff | mask_in;
               minutes_in = s1_item_ff.action_count;
            end
            ACT_CHIME_FAST: begin
               period_in  = fast_period_ff;
               pause_in   = lead_pause_ff;
               repeats_in = s1_item_ff.action_count;
            end
            ACT_CHIME_SLOW: begin
               period_in  = slow_period_ff;
               pause_in   = lead_pause_ff;
               repeats_in = s1_item_ff.action_count;
            end
            default: ;
         endcase
      end else begin
         // chime: count down the pause, then strike and reload
         if (pause_ff != 8'd0) begin
            pause_in = pause_ff - 8'd1;
            if (pause_in == 8'd0) begin
               repeats_in = repeats_ff - 8'd1;
               if (repeats_in == 8'd0) begin
                  period_in = 8'd0;
               end
               pause_in = period_in;
               pulse_in = pulse_len_ff;
               relay_in = relay_in | mask_in;
            end
         end
         // chime pulse off
         if (pulse_in != 8'd0) begin
            pulse_in = pulse_in - 8'd1;
            if (pulse_in == 8'd0) begin
               relay_in = relay_in & ~mask_in;
            end
         end
         // prescalers and timed-off countdowns
         pre_fifty_in = pre_fifty_ff + 3'd1;
         if (pre_fifty_in >= FIFTY_DIV) begin
            pre_fifty_in  = 3'd0;
            pre_second_in = pre_second_ff + 5'd1;
            if (pre_second_in >= SECOND_DIV) begin
               pre_second_in = 5'd0;
               if (seconds_ff != 8'd0) begin
                  seconds_in = seconds_ff - 8'd1;
                  if (seconds_in == 8'd0) begin
                     relay_in = relay_in & ~mask_in;
                  end
               end
               pre_minute_in = pre_minute_ff + 6'd1;
               if (pre_minute_in >= MINUTE_DIV) begin
                  pre_minute_in = 6'd0;
                  if (minutes_ff != 8'd0) begin
                     minutes_in = minutes_ff - 8'd1;
                     if (minutes_in == 8'd0) begin
                        relay_in = relay_in & ~mask_in;
                     end
                  end
               end
            end
         end
         // local switch toggles relay one
         if (fire_sw) begin
            relay_in = relay_in ^ 2'b01;
         end
      end

      rsp_data_in = {fire_b2 && tick, fire_b1 && tick, relay_in[1], relay_in[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= '0;
         mask_ff       <= '0;
         pause_ff      <= '0;
         period_ff     <= '0;
         repeats_ff    <= '0;
         pulse_ff      <= '0;
         seconds_ff    <= '0;
         minutes_ff    <= '0;
         pre_fifty_ff  <= '0;
         pre_second_ff <= '0;
         pre_minute_ff <= '0;
      end else if (advance) begin
         relay_ff      <= relay_in;
         mask_ff       <= mask_in;
         pause_ff      <= pause_in;
         period_ff     <= period_in;
         repeats_ff    <= repeats_in;
         pulse_ff      <= pulse_in;
         seconds_ff    <= seconds_in;
         minutes_ff    <= minutes_in;
         pre_fifty_ff  <= pre_fifty_in;
         pre_second_ff <= pre_second_in;
         pre_minute_ff <= pre_minute_in;
      end
   end

endmodule

`default_nettype wire
